### src/rgbgd_pkg.sv
// ----------------------------------------------------------------------------
// rgbgd_pkg
// Shared types, constants and arithmetic helpers for the RGB565 gray
// error-diffusion ditherer.
// ----------------------------------------------------------------------------
package rgbgd_pkg;

    localparam int PIXEL_W     = 16;
    localparam int GRAY_W      = 8;
    localparam int ERR_W       = 6;
    localparam int ROW_W       = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam int HEIGHT_LIMIT = 1024;
    localparam int WIDTH_RESET  = 960;
    localparam int HEIGHT_RESET = 540;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    typedef logic signed [ERR_W-1:0] err_t;

    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_col;
        logic last_row;
    } ctl_t;

    typedef struct packed {
        err_t right;
        err_t below_left;
        err_t below;
        err_t below_right;
    } shares_t;

    // nearest of 16 levels: floor((v + 8) / 17) via reciprocal 241/4096
    function automatic logic [3:0] level_of(input logic [GRAY_W-1:0] v);
        logic [15:0] prod;
        prod = 16'({1'b0, v} + 9'd8) * 16'd241;
        return prod[15:12];
    endfunction

    // floor(k * e / 16)
    function automatic err_t share_of(input logic signed [4:0] e, input logic [2:0] k);
        logic signed [8:0] prod;
        prod = 9'(e) * $signed({6'b0, k});
        return ERR_W'(prod >>> 4);
    endfunction

    // gray level back to rgb565 with bytes swapped
    function automatic logic [PIXEL_W-1:0] pack_gray(input logic [GRAY_W-1:0] q);
        logic [PIXEL_W-1:0] packed_px;
        packed_px = {q[7:3], q[7:2], q[7:3]};
        return {packed_px[7:0], packed_px[15:8]};
    endfunction

endpackage

### src/rgbgd_if.sv
// ----------------------------------------------------------------------------
// rgbgd_if
// Channel interfaces of the ditherer: input pixels, dithered results and
// register writes.
// ----------------------------------------------------------------------------
interface rgbgd_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [rgbgd_pkg::PIXEL_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface rgbgd_result_if;
    logic                          valid;
    logic                          ready;
    logic [rgbgd_pkg::PIXEL_W-1:0] pixel_out;
    logic                          frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface rgbgd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rgbgd_pkg::CFG_INDEX_W-1:0] index;
    logic [rgbgd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/rgbgd_err_ram.sv
// ----------------------------------------------------------------------------
// rgbgd_err_ram
// Row error store: one write and one read port, registered read data,
// write-through when a read meets a write to the same entry.
// ----------------------------------------------------------------------------
module rgbgd_err_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  rgbgd_pkg::err_t       wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output rgbgd_pkg::err_t       rdata
);

    rgbgd_pkg::err_t mem [DEPTH];
    rgbgd_pkg::err_t rd_data_reg;
    rgbgd_pkg::err_t byp_data_reg;
    logic            byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg  <= mem[raddr];
            byp_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (re)
        begin
            byp_hit_reg <= we && (waddr == raddr);
        end
    end

    assign rdata = byp_hit_reg ? byp_data_reg : rd_data_reg;

endmodule

### src/rgbgd_diffuse.sv
// ----------------------------------------------------------------------------
// rgbgd_diffuse
// Adds the carried error to a gray value, clamps, quantizes to 16 levels
// and splits the residual into the four neighbor shares.
// ----------------------------------------------------------------------------
module rgbgd_diffuse (
    input  logic [rgbgd_pkg::GRAY_W-1:0]  gray,
    input  rgbgd_pkg::err_t               row_err,
    input  rgbgd_pkg::err_t               carry,
    output logic [rgbgd_pkg::PIXEL_W-1:0] pixel_out,
    output rgbgd_pkg::shares_t            shares
);

    logic signed [9:0]                sum;
    logic [rgbgd_pkg::GRAY_W-1:0]     v;
    logic [3:0]                       lvl;
    logic [rgbgd_pkg::GRAY_W-1:0]     q;
    logic signed [9:0]                resid;
    logic signed [4:0]                e;

    always_comb
    begin
        sum = $signed({2'b00, gray}) + 10'(row_err) + 10'(carry);
        if (sum < 0)
        begin
            v = '0;
        end
        else if (sum > 10'sd255)
        begin
            v = 8'd255;
        end
        else
        begin
            v = sum[7:0];
        end
        lvl   = rgbgd_pkg::level_of(v);
        q     = {lvl, lvl};
        resid = $signed({2'b00, v}) - $signed({2'b00, q});
        e     = resid[4:0];

        pixel_out          = rgbgd_pkg::pack_gray(q);
        shares.right       = rgbgd_pkg::share_of(e, 3'd7);
        shares.below_left  = rgbgd_pkg::share_of(e, 3'd3);
        shares.below       = rgbgd_pkg::share_of(e, 3'd5);
        shares.below_right = rgbgd_pkg::share_of(e, 3'd1);
    end

endmodule

### src/rgb565_gray_error_diffusion_dither_core.sv
// ----------------------------------------------------------------------------
// rgb565_gray_error_diffusion_dither_core
// Floyd-Steinberg dither of byte-swapped RGB565 pixels to 16 gray levels,
// with the next-row errors kept in a single-port-pair row memory.
//
//   channel  role   transaction
//   pixel    sink   one raster-order pixel (pixel_in)
//   result   source one dithered pixel (pixel_out, frame_end)
//   cfg      sink   register write (index 0 width, 1 height), always ready
//
// One pixel per cycle sustained while the result is taken; the row memory is read and stage 1
// is loaded on accept, then stage 1 is quantized into the output register, raising result valid.
// The loop that sets the rate is the right-neighbor error carry in stage 1.
// Reset needs no clearing pass: first-row reads of the row memory are masked.
// A stalled result holds stage 1 and, behind it, the pixel channel.
// ----------------------------------------------------------------------------
module rgb565_gray_error_diffusion_dither_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    rgbgd_pixel_if.sink     pixel,
    rgbgd_result_if.source  result,
    rgbgd_cfg_if.sink       cfg
);

    localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_RST_LST = (rgbgd_pkg::WIDTH_RESET > MAX_WIDTH) ?
                               MAX_WIDTH - 1 : rgbgd_pkg::WIDTH_RESET - 1;
    localparam int H_RST_LST = rgbgd_pkg::HEIGHT_RESET - 1;

    logic [CW-1:0]                   w_last_reg;
    logic [rgbgd_pkg::ROW_W-1:0]     h_last_reg;
    logic [CW-1:0]                   col_reg;
    logic [rgbgd_pkg::ROW_W-1:0]     row_reg;

    logic                            s1_valid_reg;
    logic [rgbgd_pkg::GRAY_W-1:0]    gray_reg;
    logic [CW-1:0]                   s1_col_reg;
    rgbgd_pkg::ctl_t                 ctl_reg;

    rgbgd_pkg::err_t                 carry_reg;
    rgbgd_pkg::err_t                 pend_cur_reg;
    rgbgd_pkg::err_t                 pend_prev_reg;
    rgbgd_pkg::err_t                 pend_prev_next;
    rgbgd_pkg::err_t                 tail_reg;

    logic                            out_valid_reg;
    logic [rgbgd_pkg::PIXEL_W-1:0]   pixel_out_reg;
    logic                            frame_end_reg;

    logic                            in_fire;
    logic                            s1_go;
    logic                            cfg_fire;
    logic [rgbgd_pkg::PIXEL_W-1:0]   px;
    logic [17:0]                     gray_sum;
    logic [rgbgd_pkg::GRAY_W-1:0]    gray;
    rgbgd_pkg::ctl_t                 ctl_next;

    rgbgd_pkg::err_t                 ram_q;
    logic                            ram_we;
    logic [CW-1:0]                   ram_waddr;
    rgbgd_pkg::err_t                 ram_wdata;

    rgbgd_pkg::err_t                 row_err;
    rgbgd_pkg::err_t                 carry;
    logic [rgbgd_pkg::PIXEL_W-1:0]   pixel_q;
    rgbgd_pkg::shares_t              shares;

    assign cfg.ready     = 1'b1;
    assign cfg_fire      = cfg.valid;
    assign s1_go         = s1_valid_reg && (!out_valid_reg || result.ready);
    assign pixel.ready   = !s1_valid_reg || s1_go;
    assign in_fire       = pixel.valid && pixel.ready;

    assign result.valid     = out_valid_reg;
    assign result.pixel_out = pixel_out_reg;
    assign result.frame_end = frame_end_reg;

    // byte swap, widen, luma weights
    always_comb
    begin
        px       = {pixel.pixel_in[7:0], pixel.pixel_in[15:8]};
        gray_sum = 18'({px[15:11], 3'b000}) * 18'd306
                 + 18'({px[10:5], 2'b00}) * 18'd601
                 + 18'({px[4:0], 3'b000}) * 18'd117;
        gray     = gray_sum[17:10];

        ctl_next.first_row = (row_reg == '0);
        ctl_next.first_col = (col_reg == '0);
        ctl_next.last_col  = (col_reg == w_last_reg);
        ctl_next.last_row  = (row_reg == h_last_reg);
    end

    // register writes and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= CW'(W_RST_LST);
            h_last_reg <= rgbgd_pkg::ROW_W'(H_RST_LST);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                rgbgd_pkg::REG_IMAGE_WIDTH:
                begin
                    if (cfg.data == '0)
                    begin
                        w_last_reg <= '0;
                    end
                    else if (int'(cfg.data) > MAX_WIDTH)
                    begin
                        w_last_reg <= CW'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        w_last_reg <= CW'(cfg.data - 1'b1);
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                end
                rgbgd_pkg::REG_IMAGE_HEIGHT:
                begin
                    if (cfg.data == '0)
                    begin
                        h_last_reg <= '0;
                    end
                    else if (int'(cfg.data) > rgbgd_pkg::HEIGHT_LIMIT)
                    begin
                        h_last_reg <= rgbgd_pkg::ROW_W'(rgbgd_pkg::HEIGHT_LIMIT - 1);
                    end
                    else
                    begin
                        h_last_reg <= rgbgd_pkg::ROW_W'(cfg.data - 1'b1);
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_fire)
        begin
            if (ctl_next.last_col)
            begin
                col_reg <= '0;
                row_reg <= ctl_next.last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // stage 1 and result valid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            gray_reg   <= gray;
            s1_col_reg <= col_reg;
            ctl_reg    <= ctl_next;
        end
    end

    rgbgd_err_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_err_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (col_reg),
        .rdata (ram_q)
    );

    // row error from above (last column kept in a register), carry from left, row memory write
    always_comb
    begin
        if (ctl_reg.first_row)
        begin
            row_err = '0;
        end
        else if (ctl_reg.last_col)
        begin
            row_err = tail_reg;
        end
        else
        begin
            row_err = ram_q;
        end
        carry = ctl_reg.first_col ? '0 : carry_reg;

        pend_prev_next = (ctl_reg.first_col ? '0 : pend_cur_reg) + shares.below;
        ram_we         = s1_go && !ctl_reg.first_col;
        ram_waddr      = s1_col_reg - 1'b1;
        ram_wdata      = pend_prev_reg + shares.below_left;
    end

    rgbgd_diffuse u_diffuse (
        .gray      (gray_reg),
        .row_err   (row_err),
        .carry     (carry),
        .pixel_out (pixel_q),
        .shares    (shares)
    );

    // error partial sums and result register
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            carry_reg     <= shares.right;
            pend_cur_reg  <= shares.below_right;
            pend_prev_reg <= pend_prev_next;
            if (ctl_reg.last_col)
            begin
                tail_reg <= pend_prev_next;
            end
            pixel_out_reg <= pixel_q;
            frame_end_reg <= ctl_reg.last_col && ctl_reg.last_row;
        end
    end

endmodule

### tb/sv/tb_rgb565_gray_error_diffusion_dither_core.sv
// ----------------------------------------------------------------------------
// tb_rgb565_gray_error_diffusion_dither_core
// Self-checking bench for the gray error-diffusion ditherer. Pixels from a
// backlog are sent with random gaps, results are taken with random stalls and
// compared against an in-bench dither predictor that tracks the row error
// stores, the frame position and the width and height registers.
// ----------------------------------------------------------------------------
module tb_rgb565_gray_error_diffusion_dither_core;

    localparam int MAX_W       = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 420;

    localparam logic [rgbgd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A =
        rgbgd_pkg::CFG_INDEX_W'(2);
    localparam logic [rgbgd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B =
        rgbgd_pkg::CFG_INDEX_W'(3);

    typedef enum int {MIX_RANDOM, MIX_LEVELS, MIX_DARK, MIX_BRIGHT} pixel_mix_t;

    typedef struct {
        logic [rgbgd_pkg::PIXEL_W-1:0] pixel_out;
        logic                          frame_end;
    } dither_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rgbgd_pixel_if  pix_if ();
    rgbgd_result_if res_if ();
    rgbgd_cfg_if    cfg_if ();

    rgb565_gray_error_diffusion_dither_core #(
        .MAX_WIDTH (MAX_W)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // predictor state
    logic [rgbgd_pkg::CFG_DATA_W-1:0] width_reg;
    logic [rgbgd_pkg::CFG_DATA_W-1:0] height_reg;
    rgbgd_pkg::err_t                  err_cur [MAX_W];
    rgbgd_pkg::err_t                  err_nxt [MAX_W];
    int unsigned                      col_pos;
    int unsigned                      row_pos;

    logic [rgbgd_pkg::PIXEL_W-1:0] pixel_backlog [$];
    dither_out_t                   gray_expected [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  idle_en = 1'b1;
    int  send_gap = 0;
    int  stall_len = 0;
    bit  send_hold;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void backlog_add(input logic [rgbgd_pkg::PIXEL_W-1:0] px);
        pixel_backlog.insert(pixel_backlog.size(), px);
    endfunction

    function automatic void expected_add(input dither_out_t res);
        gray_expected.insert(gray_expected.size(), res);
    endfunction

    function automatic void clear_frame();
        foreach (err_cur[i])
        begin
            err_cur[i] = '0;
            err_nxt[i] = '0;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void apply_reg(input logic [rgbgd_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [rgbgd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            rgbgd_pkg::REG_IMAGE_WIDTH:
            begin
                width_reg = val;
                clear_frame();
            end
            rgbgd_pkg::REG_IMAGE_HEIGHT:
            begin
                height_reg = val;
                clear_frame();
            end
            default: ;
        endcase
    endfunction

    function automatic dither_out_t dither_pixel(
        input logic [rgbgd_pkg::PIXEL_W-1:0] raw);
        int unsigned   w;
        int unsigned   h;
        int unsigned   x;
        int unsigned   y;
        int            r;
        int            g;
        int            b;
        int            gray;
        int            v;
        int            q;
        int            e;
        logic [15:0]   p;
        logic [7:0]    q8;
        logic [15:0]   pk;
        bit            last_col;
        bit            last_row;
        dither_out_t   res;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h = (height_reg == 0) ? 1 :
            ((height_reg > rgbgd_pkg::HEIGHT_LIMIT) ? rgbgd_pkg::HEIGHT_LIMIT : height_reg);
        x = (col_pos >= w) ? w - 1 : col_pos;
        y = (row_pos >= h) ? h - 1 : row_pos;
        last_col = (x + 1 >= w);
        last_row = (y + 1 >= h);

        p = {raw[7:0], raw[15:8]};
        r = int'({p[15:11], 3'b000});
        g = int'({p[10:5], 2'b00});
        b = int'({p[4:0], 3'b000});
        gray = (r * 306 + g * 601 + b * 117) >>> 10;

        v = gray + int'(err_cur[x]);
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        q = ((v + 8) / 17) * 17;
        if (q > 255)
            q = 255;
        e = v - q;

        q8 = q[7:0];
        pk = {q8[7:3], q8[7:2], q8[7:3]};
        res.pixel_out = {pk[7:0], pk[15:8]};
        res.frame_end = 1'b0;

        // floor shares via arithmetic shift
        if (!last_col)
            err_cur[x+1] = rgbgd_pkg::err_t'(int'(err_cur[x+1]) + ((e * 7) >>> 4));
        if (!last_row)
        begin
            if (x > 0)
                err_nxt[x-1] = rgbgd_pkg::err_t'(int'(err_nxt[x-1]) + ((e * 3) >>> 4));
            err_nxt[x] = rgbgd_pkg::err_t'(int'(err_nxt[x]) + ((e * 5) >>> 4));
            if (!last_col)
                err_nxt[x+1] = rgbgd_pkg::err_t'(int'(err_nxt[x+1]) + (e >>> 4));
        end

        if (last_col)
        begin
            if (last_row)
            begin
                res.frame_end = 1'b1;
                clear_frame();
            end
            else
            begin
                err_cur = err_nxt;
                foreach (err_nxt[i])
                    err_nxt[i] = '0;
                col_pos = 0;
                row_pos = y + 1;
            end
        end
        else
        begin
            col_pos = x + 1;
            row_pos = y;
        end
        return res;
    endfunction

    function automatic logic [rgbgd_pkg::PIXEL_W-1:0] gray_pixel(input int lvl,
                                                                 input bit jitter);
        logic [7:0]  l;
        logic [15:0] p;
        l = lvl[7:0];
        p = {l[7:3], l[7:2], l[7:3]};
        if (jitter)
            p = p ^ {5'($urandom_range(0, 1)), 6'($urandom_range(0, 3)),
                     5'($urandom_range(0, 1))};
        return {p[7:0], p[15:8]};
    endfunction

    function automatic logic [rgbgd_pkg::PIXEL_W-1:0] make_pixel(input pixel_mix_t mix);
        case (mix)
            MIX_LEVELS: return gray_pixel($urandom_range(0, 255), 1'b1);
            MIX_DARK:   return gray_pixel($urandom_range(0, 24), 1'b1);
            MIX_BRIGHT: return gray_pixel($urandom_range(230, 255), 1'b1);
            default:    return rgbgd_pkg::PIXEL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // pixel driver, predicts on every accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_if.valid    <= 1'b0;
            pix_if.pixel_in <= '0;
            send_gap = 0;
        end
        else
        begin
            send_hold = pix_if.valid && !pix_if.ready;
            if (pix_if.valid && pix_if.ready)
                expected_add(dither_pixel(pix_if.pixel_in));
            if (!send_hold)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pix_if.valid <= 1'b0;
                end
                else if (pixel_backlog.size() > 0)
                begin
                    pix_if.pixel_in <= pixel_backlog.pop_front();
                    pix_if.valid    <= 1'b1;
                    if (idle_en && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 13);
                end
                else
                    pix_if.valid <= 1'b0;
            end
        end
    end

    // result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_len = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (gray_expected.size() == 0)
                begin
                    $error("unexpected result: pixel_out %h frame_end %b",
                           res_if.pixel_out, res_if.frame_end);
                    mismatches++;
                end
                else
                begin
                    dither_out_t exp_res;
                    exp_res = gray_expected.pop_front();
                    if (res_if.pixel_out !== exp_res.pixel_out)
                    begin
                        $error("pixel_out: expected %h, actual %h",
                               exp_res.pixel_out, res_if.pixel_out);
                        mismatches++;
                    end
                    if (res_if.frame_end !== exp_res.frame_end)
                    begin
                        $error("frame_end: expected %b, actual %b",
                               exp_res.frame_end, res_if.frame_end);
                        mismatches++;
                    end
                end
            end
            if (stall_len > 0)
            begin
                stall_len--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0)
                    stall_len = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rgb565_gray_error_diffusion_dither_core regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (!(pixel_backlog.size() == 0 && !pix_if.valid && gray_expected.size() == 0))
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [rgbgd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rgbgd_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        apply_reg(idx, val);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_frames(input int wv, input int hv, input int count,
                              input pixel_mix_t mix);
        wait_drained();
        write_reg(rgbgd_pkg::REG_IMAGE_WIDTH, rgbgd_pkg::CFG_DATA_W'(wv));
        write_reg(rgbgd_pkg::REG_IMAGE_HEIGHT, rgbgd_pkg::CFG_DATA_W'(hv));
        repeat (count)
            backlog_add(make_pixel(mix));
    endtask

    initial
    begin
        int w;
        int h;
        int count;
        int rand_items;
        pix_if.valid    = 1'b0;
        pix_if.pixel_in = '0;
        res_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        width_reg  = rgbgd_pkg::CFG_DATA_W'(rgbgd_pkg::WIDTH_RESET);
        height_reg = rgbgd_pkg::CFG_DATA_W'(rgbgd_pkg::HEIGHT_RESET);
        clear_frame();
        rand_items = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // channel extremes at the reset geometry
        backlog_add(16'h0000);
        backlog_add(16'hFFFF);
        backlog_add(16'h00F8);
        backlog_add(16'hE007);
        backlog_add(16'h1F00);
        backlog_add(16'h00FF);
        backlog_add(16'hFF00);
        backlog_add(16'h5555);
        backlog_add(16'hAAAA);

        // small frames with largest positive and negative residuals
        wait_drained();
        write_reg(rgbgd_pkg::REG_IMAGE_WIDTH, rgbgd_pkg::CFG_DATA_W'(3));
        write_reg(rgbgd_pkg::REG_IMAGE_HEIGHT, rgbgd_pkg::CFG_DATA_W'(2));
        repeat (6) backlog_add(gray_pixel(8, 1'b0));
        repeat (6) backlog_add(gray_pixel(9, 1'b0));

        // zero width and height act as one, spare indexes do nothing
        wait_drained();
        write_reg(rgbgd_pkg::REG_IMAGE_WIDTH, '0);
        write_reg(rgbgd_pkg::REG_IMAGE_HEIGHT, '0);
        backlog_add(16'hFFFF);
        wait_drained();
        write_reg(REG_SPARE_A, rgbgd_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
        write_reg(REG_SPARE_B, rgbgd_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
        backlog_add(16'h0000);
        backlog_add(16'h1234);

        // spare write in the middle of a frame
        run_frames(4, 3, 5, MIX_LEVELS);
        wait_drained();
        write_reg(REG_SPARE_A, '1);
        repeat (7) backlog_add(make_pixel(MIX_RANDOM));

        while (rand_items < RANDOM_ITEMS)
        begin
            idle_en = ($urandom_range(0, 3) != 0);
            w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            h = $urandom_range(1, 6);
            count = w * h * $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0)
                count = $urandom_range(1, count);
            if (count > RANDOM_ITEMS - rand_items)
                count = RANDOM_ITEMS - rand_items;
            if ($urandom_range(0, 15) == 0)
                w = 0;
            if ($urandom_range(0, 15) == 0)
                h = 0;
            run_frames(w, h, count, pixel_mix_t'($urandom_range(0, 3)));
            rand_items += count;
        end

        // widest and tallest frames, over-range values clamp
        idle_en = 1'b1;
        run_frames(2047, 2, 12, MIX_RANDOM);
        run_frames(1, 2047, 12, MIX_LEVELS);
        run_frames(1024, 3, 12, MIX_DARK);
        run_frames(1025, 1024, 12, MIX_BRIGHT);
        run_frames(1024, 1024, 12, MIX_RANDOM);

        // closing stretch at full rate
        idle_en = 1'b0;
        run_frames(8, 5, 80, MIX_RANDOM);

        wait_drained();
        repeat (8) @(posedge clk);
        if (gray_expected.size() != 0)
        begin
            $error("results missing: %0d still expected", gray_expected.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("rgb565_gray_error_diffusion_dither_core regression: pass");
        else
            $display("rgb565_gray_error_diffusion_dither_core regression: fail");
        $finish;
    end

endmodule
